[rtl/mac_keyed_peer_table_core_defines.svh]
// Assertion macros shared by the peer table RTL.
`ifndef MAC_KEYED_PEER_TABLE_CORE_DEFINES_SVH
`define MAC_KEYED_PEER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define MKPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("peer table check failed");

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define MKPT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("peer table check failed");

`endif

[rtl/mkpt_pkg.sv]
// Shared types and constants of the MAC keyed peer table.
package mkpt_pkg;

  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int MAC_W     = 48;
  localparam int BYTE_W    = 8;

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]  peer_mac;
    logic [MAC_W-1:0]  owner_mac;
    logic [BYTE_W-1:0] active_profile;
    logic [BYTE_W-1:0] default_profile;
    logic [BYTE_W-1:0] dev_state;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/mkpt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mkpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mac_keyed_peer_table_core.sv]
// Top level of the MAC keyed peer table: sequencer, entry RAM and response register.
//
// The block keeps up to sixteen peers keyed by MAC address and serves one
// request at a time. Upsert and find walk the filled slots from slot 0 upward
// through the single read port of the entry RAM, one slot per cycle with the
// key compare in the cycle after the read of its slot. A read by index goes
// through the RAM only when the index is filled; a read of an unfilled index
// and a clear are answered straight from the idle state.
// An upsert writes its entry in the cycle that ends the search. The response
// is held in registers until rsp_ready is seen, and req_ready stays low from
// acceptance until the response has been taken. The controller MAC register
// may be written at any time the block is idle and takes effect at the next
// request. Slots that were never written hold unknown data, but only slots
// below the fill count are ever reported, so no clearing pass is needed after
// reset.
module mac_keyed_peer_table_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         controller_mac_we,
  input  logic [mkpt_pkg::MAC_W-1:0]   controller_mac_wdata,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   opcode,
  input  logic [mkpt_pkg::MAC_W-1:0]   key_mac,
  input  logic [mkpt_pkg::IDX_W-1:0]   entry_index,
  input  logic [mkpt_pkg::BYTE_W-1:0]  new_active_profile,
  input  logic [mkpt_pkg::BYTE_W-1:0]  new_default_profile,
  input  logic [mkpt_pkg::BYTE_W-1:0]  new_device_state,
  input  logic [mkpt_pkg::MAC_W-1:0]   new_owner_mac,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [1:0]                   status,
  output logic [mkpt_pkg::IDX_W-1:0]   slot,
  output logic [mkpt_pkg::MAC_W-1:0]   out_peer_mac,
  output logic [mkpt_pkg::BYTE_W-1:0]  out_active_profile,
  output logic [mkpt_pkg::BYTE_W-1:0]  out_default_profile,
  output logic [mkpt_pkg::BYTE_W-1:0]  out_device_state,
  output logic [mkpt_pkg::MAC_W-1:0]   out_owner_mac,
  output logic                         owned_by_other,
  output logic [mkpt_pkg::CNT_W-1:0]   occupancy
);

  import mkpt_pkg::*;

  `include "mac_keyed_peer_table_core_defines.svh"

  state_t            state, state_next;
  logic [MAC_W-1:0]  self_mac;
  logic [CNT_W-1:0]  fill_count, fill_count_next;

  // Scan pointers: issue_idx is the next slot to read, cmp_idx the slot whose
  // data sits on the RAM output when cmp_valid is set.
  logic [CNT_W-1:0]  issue_idx, issue_idx_next;
  logic              cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0]  cmp_idx, cmp_idx_next;

  // Captured request.
  op_t               op_q;
  logic [MAC_W-1:0]  key_q;
  logic [BYTE_W-1:0] act_q, def_q, dev_q;
  logic [MAC_W-1:0]  own_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_rdata, new_entry;

  logic              accept, scan_hit, scan_more;
  logic              rsp_load, sel_none;
  entry_t            sel_entry;
  logic [IDX_W-1:0]  sel_slot;
  status_t           sel_status;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);

  assign scan_hit  = cmp_valid && (ram_rdata.peer_mac == key_q);
  assign scan_more = (issue_idx < fill_count);

  assign new_entry = '{peer_mac:        key_q,
                       owner_mac:       own_q,
                       active_profile:  act_q,
                       default_profile: def_q,
                       dev_state:       dev_q};

  mkpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PEERS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (new_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (op_t'(opcode))
            OP_UPSERT, OP_FIND: state_next = ST_SCAN;
            OP_READ: begin
              state_next = ({1'b0, entry_index} < fill_count) ? ST_READ : ST_RESP;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit || !scan_more) begin
          state_next = ST_RESP;
        end
      end
      ST_READ: state_next = ST_RESP;
      ST_RESP: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control: RAM access, scan pointers, fill count and the response.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = cmp_idx;
    ram_raddr       = issue_idx[IDX_W-1:0];
    fill_count_next = fill_count;
    issue_idx_next  = issue_idx;
    cmp_valid_next  = 1'b0;
    cmp_idx_next    = cmp_idx;
    rsp_load        = 1'b0;
    sel_entry       = ram_rdata;
    sel_slot        = cmp_idx;
    sel_status      = STATUS_OK;
    sel_none        = 1'b1;
    case (state)
      ST_IDLE: begin
        issue_idx_next = '0;
        ram_raddr      = entry_index;
        cmp_idx_next   = entry_index;
        if (req_valid) begin
          case (op_t'(opcode))
            OP_CLEAR: begin
              fill_count_next = '0;
              rsp_load        = 1'b1;
            end
            OP_READ: begin
              if ({1'b0, entry_index} >= fill_count) begin
                sel_status = STATUS_NOT_FOUND;
                rsp_load   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          rsp_load = 1'b1;
          sel_none = 1'b0;
          if (op_q == OP_UPSERT) begin
            ram_we    = 1'b1;
            sel_entry = new_entry;
          end
        end else if (scan_more) begin
          issue_idx_next = issue_idx + CNT_W'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = issue_idx[IDX_W-1:0];
        end else begin
          rsp_load = 1'b1;
          if (op_q != OP_UPSERT) begin
            sel_status = STATUS_NOT_FOUND;
          end else if (fill_count >= CNT_W'(MAX_PEERS)) begin
            sel_status = STATUS_FULL;
          end else begin
            // Append the key at the first free slot.
            ram_we          = 1'b1;
            ram_waddr       = fill_count[IDX_W-1:0];
            sel_slot        = fill_count[IDX_W-1:0];
            sel_entry       = new_entry;
            sel_none        = 1'b0;
            fill_count_next = fill_count + CNT_W'(1);
          end
        end
      end
      ST_READ: begin
        rsp_load = 1'b1;
        sel_none = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      self_mac   <= '0;
      fill_count <= '0;
      issue_idx  <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      issue_idx  <= issue_idx_next;
      cmp_valid  <= cmp_valid_next;
      if (controller_mac_we) begin
        self_mac <= controller_mac_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    if (accept) begin
      op_q  <= op_t'(opcode);
      key_q <= key_mac;
      act_q <= new_active_profile;
      def_q <= new_default_profile;
      dev_q <= new_device_state;
      own_q <= new_owner_mac;
    end
    if (rsp_load) begin
      status    <= sel_status;
      occupancy <= fill_count_next;
      if (sel_none) begin
        slot                <= '0;
        out_peer_mac        <= '0;
        out_active_profile  <= '0;
        out_default_profile <= '0;
        out_device_state    <= '0;
        out_owner_mac       <= '0;
        owned_by_other      <= 1'b0;
      end else begin
        slot                <= sel_slot;
        out_peer_mac        <= sel_entry.peer_mac;
        out_active_profile  <= sel_entry.active_profile;
        out_default_profile <= sel_entry.default_profile;
        out_device_state    <= sel_entry.dev_state;
        out_owner_mac       <= sel_entry.owner_mac;
        owned_by_other      <= (sel_entry.owner_mac != '0) &&
                               (sel_entry.owner_mac != self_mac);
      end
    end
  end

  `MKPT_ASSERT_NXT(a_busy_after_accept, accept, !req_ready)
  `MKPT_ASSERT_IMP(a_write_only_in_scan, ram_we, state == ST_SCAN)
  `MKPT_ASSERT_IMP(a_fill_in_range, state != ST_IDLE, fill_count <= CNT_W'(MAX_PEERS))
  `MKPT_ASSERT_IMP(a_occupancy_tracks_fill, rsp_valid, occupancy == fill_count)
  `MKPT_ASSERT_IMP(a_no_entry_on_error, rsp_valid && (status != STATUS_OK),
                   (slot == '0) && !owned_by_other)

endmodule

[bench/tb_mac_keyed_peer_table_core.sv]
// Self-checking testbench for the MAC keyed peer table core.
module tb_mac_keyed_peer_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mkpt_pkg::*;

  // One request as the sender offers it to the block.
  typedef struct {
    op_t               opcode;
    logic [MAC_W-1:0]  key_mac;
    logic [IDX_W-1:0]  entry_index;
    logic [BYTE_W-1:0] active_profile;
    logic [BYTE_W-1:0] default_profile;
    logic [BYTE_W-1:0] dev_state;
    logic [MAC_W-1:0]  owner_mac;
  } table_req_t;

  // One response, laid out so that a single compare covers every field.
  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  slot;
    logic [MAC_W-1:0]  peer_mac;
    logic [BYTE_W-1:0] active_profile;
    logic [BYTE_W-1:0] default_profile;
    logic [BYTE_W-1:0] dev_state;
    logic [MAC_W-1:0]  owner_mac;
    logic              owned_by_other;
    logic [CNT_W-1:0]  occupancy;
  } table_rsp_t;

  localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};
  localparam int POOL_SIZE = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic              controller_mac_we    = 1'b0;
  logic [MAC_W-1:0]  controller_mac_wdata = '0;
  logic              req_valid            = 1'b0;
  logic [1:0]        opcode               = '0;
  logic [MAC_W-1:0]  key_mac              = '0;
  logic [IDX_W-1:0]  entry_index          = '0;
  logic [BYTE_W-1:0] new_active_profile   = '0;
  logic [BYTE_W-1:0] new_default_profile  = '0;
  logic [BYTE_W-1:0] new_device_state     = '0;
  logic [MAC_W-1:0]  new_owner_mac        = '0;
  logic              rsp_ready            = 1'b0;

  logic              req_ready;
  logic              rsp_valid;
  logic [1:0]        status;
  logic [IDX_W-1:0]  slot;
  logic [MAC_W-1:0]  out_peer_mac;
  logic [BYTE_W-1:0] out_active_profile;
  logic [BYTE_W-1:0] out_default_profile;
  logic [BYTE_W-1:0] out_device_state;
  logic [MAC_W-1:0]  out_owner_mac;
  logic              owned_by_other;
  logic [CNT_W-1:0]  occupancy;

  // Requests waiting to be offered, and the responses the table owes us.
  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];
  table_req_t offered_req;

  // Our own copy of the peer table and of the controller MAC register.
  logic [MAC_W-1:0]  tbl_peer_mac[MAX_PEERS];
  logic [MAC_W-1:0]  tbl_owner_mac[MAX_PEERS];
  logic [BYTE_W-1:0] tbl_active[MAX_PEERS];
  logic [BYTE_W-1:0] tbl_default[MAX_PEERS];
  logic [BYTE_W-1:0] tbl_state[MAX_PEERS];
  int                tbl_fill = 0;
  logic [MAC_W-1:0]  ctrl_mac_model = '0;

  // Keys for the random part are mostly drawn from a small pool so that upserts
  // hit existing entries, finds succeed and the table regularly runs full.
  logic [MAC_W-1:0]  mac_pool[POOL_SIZE];

  int unsigned cycle_count   = 0;
  int unsigned rsp_seen      = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;
  int unsigned mismatch_count = 0;

  // No random idling on either side inside this window.
  wire quiet = (cycle_count >= 15000) && (cycle_count < 21000);

  mac_keyed_peer_table_core dut (
    .clk                  (clk),
    .rst                  (rst),
    .controller_mac_we    (controller_mac_we),
    .controller_mac_wdata (controller_mac_wdata),
    .req_valid            (req_valid),
    .req_ready            (req_ready),
    .opcode               (opcode),
    .key_mac              (key_mac),
    .entry_index          (entry_index),
    .new_active_profile   (new_active_profile),
    .new_default_profile  (new_default_profile),
    .new_device_state     (new_device_state),
    .new_owner_mac        (new_owner_mac),
    .rsp_valid            (rsp_valid),
    .rsp_ready            (rsp_ready),
    .status               (status),
    .slot                 (slot),
    .out_peer_mac         (out_peer_mac),
    .out_active_profile   (out_active_profile),
    .out_default_profile  (out_default_profile),
    .out_device_state     (out_device_state),
    .out_owner_mac        (out_owner_mac),
    .owned_by_other       (owned_by_other),
    .occupancy            (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[MAC_W-1:0];
  endfunction

  // Response that reports the contents of one filled slot.
  function automatic table_rsp_t entry_view(int s);
    table_rsp_t rsp;
    rsp                 = '0;
    rsp.status          = STATUS_OK;
    rsp.slot            = s[IDX_W-1:0];
    rsp.peer_mac        = tbl_peer_mac[s];
    rsp.active_profile  = tbl_active[s];
    rsp.default_profile = tbl_default[s];
    rsp.dev_state       = tbl_state[s];
    rsp.owner_mac       = tbl_owner_mac[s];
    rsp.owned_by_other  = (tbl_owner_mac[s] != '0) && (tbl_owner_mac[s] != ctrl_mac_model);
    return rsp;
  endfunction

  // Applies one accepted request to our copy of the table and returns the
  // response the block must give for it.
  function automatic table_rsp_t apply_table_op(table_req_t r);
    table_rsp_t rsp;
    int hit;
    int s;
    rsp = '0;
    hit = -1;
    // Scanning downward leaves the lowest matching slot, as the block's
    // upward search would find first.
    for (int i = tbl_fill - 1; i >= 0; i--) begin
      if (tbl_peer_mac[i] == r.key_mac) hit = i;
    end
    case (r.opcode)
      OP_UPSERT: begin
        if (hit < 0 && tbl_fill >= MAX_PEERS) begin
          // Unknown key on a full table: nothing changes.
          rsp.status = STATUS_FULL;
        end else begin
          if (hit >= 0) begin
            s = hit;
          end else begin
            s = tbl_fill;
            tbl_peer_mac[s] = r.key_mac;
            tbl_fill++;
          end
          tbl_active[s]    = r.active_profile;
          tbl_default[s]   = r.default_profile;
          tbl_state[s]     = r.dev_state;
          tbl_owner_mac[s] = r.owner_mac;
          rsp = entry_view(s);
        end
      end
      OP_FIND: begin
        if (hit >= 0) rsp = entry_view(hit);
        else rsp.status = STATUS_NOT_FOUND;
      end
      OP_READ: begin
        if (r.entry_index < tbl_fill) rsp = entry_view(r.entry_index);
        else rsp.status = STATUS_NOT_FOUND;
      end
      default: begin
        // Clear only drops the fill count; stale contents become unreachable.
        tbl_fill = 0;
      end
    endcase
    rsp.occupancy = tbl_fill[CNT_W-1:0];
    return rsp;
  endfunction

  function automatic table_req_t mk_req(op_t op, logic [MAC_W-1:0] key, int idx,
                                        int act, int dflt, int dev,
                                        logic [MAC_W-1:0] owner);
    table_req_t r;
    r.opcode          = op;
    r.key_mac         = key;
    r.entry_index     = idx[IDX_W-1:0];
    r.active_profile  = act[BYTE_W-1:0];
    r.default_profile = dflt[BYTE_W-1:0];
    r.dev_state       = dev[BYTE_W-1:0];
    r.owner_mac       = owner;
    return r;
  endfunction

  // Random request; clear_pct sets how often the table is emptied, which in
  // turn sets how often it reaches the full state.
  function automatic table_req_t random_table_req(int clear_pct);
    table_req_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < clear_pct) r.opcode = OP_CLEAR;
    else if (roll < 50) r.opcode = OP_UPSERT;
    else if (roll < 75) r.opcode = OP_FIND;
    else r.opcode = OP_READ;
    r.key_mac         = ($urandom_range(4) == 0) ? rand_mac()
                                                 : mac_pool[$urandom_range(POOL_SIZE - 1)];
    r.entry_index     = IDX_W'($urandom_range(MAX_PEERS - 1));
    r.active_profile  = BYTE_W'($urandom_range(255));
    r.default_profile = BYTE_W'($urandom_range(255));
    r.dev_state       = BYTE_W'($urandom_range(255));
    case ($urandom_range(4))
      0: r.owner_mac = '0;
      1: r.owner_mac = ctrl_mac_model;
      2: r.owner_mac = MAC_ONES;
      default: r.owner_mac = rand_mac();
    endcase
    return r;
  endfunction

  function automatic string rsp_text(table_rsp_t r);
    return $sformatf("st=%0d slot=%0d peer=%h act=%h def=%h dev=%h own=%h other=%b occ=%0d",
                     r.status, r.slot, r.peer_mac, r.active_profile, r.default_profile,
                     r.dev_state, r.owner_mac, r.owned_by_other, r.occupancy);
  endfunction

  // Waits until every request is offered, taken and answered. Levels are
  // checked at the falling edge so that no nonblocking update is in flight.
  // The extra cycles cover the block's return to ready after its last response.
  task automatic wait_table_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // The register is only written while the block is idle, so our copy can be
  // updated at the same edge without racing any request.
  task automatic write_controller_mac(logic [MAC_W-1:0] value);
    @(posedge clk);
    controller_mac_we    <= 1'b1;
    controller_mac_wdata <= value;
    ctrl_mac_model = value;
    @(posedge clk);
    controller_mac_we    <= 1'b0;
  endtask

  task automatic fill_mac_pool();
    mac_pool[0] = '0;
    mac_pool[1] = MAC_ONES;
    mac_pool[2] = ctrl_mac_model;
    for (int i = 3; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();
  endtask

  // Request driver. A request that has been offered stays on the port, payload
  // unchanged, until the block takes it. At acceptance the request is applied
  // to our table copy and its response is queued as expected.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_table_op(offered_req));
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 33)) begin
          offered_req = pending_reqs.pop_front();
          opcode              <= offered_req.opcode;
          key_mac             <= offered_req.key_mac;
          entry_index         <= offered_req.entry_index;
          new_active_profile  <= offered_req.active_profile;
          new_default_profile <= offered_req.default_profile;
          new_device_state    <= offered_req.dev_state;
          new_owner_mac       <= offered_req.owner_mac;
          req_valid           <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side ready. Once, after a few hundred responses, the receiver
  // holds off for a long stretch while the sender keeps offering requests, so
  // the block sits on a finished response and keeps its request port stalled.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rsp_seen >= 600) begin
      rsp_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      rsp_ready <= quiet || ($urandom_range(99) >= 33);
    end
  end

  // Response monitor: every response taken is checked against the oldest
  // expectation.
  always @(posedge clk) begin : rsp_monitor
    table_rsp_t got;
    table_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      got.status          = status_t'(status);
      got.slot            = slot;
      got.peer_mac        = out_peer_mac;
      got.active_profile  = out_active_profile;
      got.default_profile = out_default_profile;
      got.dev_state       = out_device_state;
      got.owner_mac       = out_owner_mac;
      got.owned_by_other  = owned_by_other;
      got.occupancy       = occupancy;
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("response %0d arrived with no request outstanding: %s",
                   rsp_seen, rsp_text(got));
        end
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("response %0d mismatch", rsp_seen);
            $display("  expected %s", rsp_text(want));
            $display("  actual   %s", rsp_text(got));
          end
        end
      end
      rsp_seen <= rsp_seen + 1;
    end
  end

  // Stimulus sequence: directed corner cases, then random phases, each under a
  // different controller MAC.
  initial begin
    logic [MAC_W-1:0] ctrl_values[6];
    logic [MAC_W-1:0] first_ctrl;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    first_ctrl = rand_mac() | 48'h1;
    write_controller_mac(first_ctrl);

    // Empty table: read and find miss, clear of an empty table is fine.
    pending_reqs.push_back(mk_req(OP_READ, '0, 0, 0, 0, 0, '0));
    pending_reqs.push_back(mk_req(OP_FIND, MAC_ONES, 0, 0, 0, 0, '0));
    pending_reqs.push_back(mk_req(OP_CLEAR, '0, 0, 0, 0, 0, '0));
    // Appends with the extremes of every field, including an owner equal to
    // the controller MAC and an all-ones owner.
    pending_reqs.push_back(mk_req(OP_UPSERT, '0, 0, 0, 0, 0, '0));
    pending_reqs.push_back(mk_req(OP_UPSERT, MAC_ONES, 15, 255, 255, 255, MAC_ONES));
    pending_reqs.push_back(mk_req(OP_UPSERT, first_ctrl, 0, 8'h5a, 8'ha5, 8'h3c, first_ctrl));
    // Upsert on a present key overwrites the entry in place.
    pending_reqs.push_back(mk_req(OP_UPSERT, '0, 0, 8'h81, 8'h7e, 8'h01, 48'h8000_0000_0001));
    pending_reqs.push_back(mk_req(OP_FIND, MAC_ONES, 0, 0, 0, 0, '0));
    // Read beyond the occupancy.
    pending_reqs.push_back(mk_req(OP_READ, '0, 15, 0, 0, 0, '0));
    // Fill the table to the last slot.
    for (int i = 0; i < 13; i++) begin
      pending_reqs.push_back(mk_req(OP_UPSERT, 48'h0a00_0000_0000 + i, 0, i, 255 - i, 16 * i,
                                    (i % 2 == 0) ? rand_mac() : '0));
    end
    // Unknown key on a full table, then a known key on a full table.
    pending_reqs.push_back(mk_req(OP_UPSERT, 48'h0b00_0000_0000, 0, 1, 2, 3, MAC_ONES));
    pending_reqs.push_back(mk_req(OP_UPSERT, MAC_ONES, 0, 9, 8, 7, '0));
    pending_reqs.push_back(mk_req(OP_READ, '0, 15, 0, 0, 0, '0));
    pending_reqs.push_back(mk_req(OP_CLEAR, '0, 0, 0, 0, 0, '0));
    pending_reqs.push_back(mk_req(OP_FIND, '0, 0, 0, 0, 0, '0));
    wait_table_idle();

    // A zero controller MAC makes every nonzero owner foreign; all ones is the
    // other extreme.
    ctrl_values[0] = '0;
    ctrl_values[1] = MAC_ONES;
    ctrl_values[2] = rand_mac();
    ctrl_values[3] = rand_mac();
    ctrl_values[4] = 48'h0000_0000_0001;
    ctrl_values[5] = rand_mac();
    for (int p = 0; p < 6; p++) begin
      write_controller_mac(ctrl_values[p]);
      fill_mac_pool();
      for (int n = 0; n < 300; n++) begin
        pending_reqs.push_back(random_table_req((p % 2 == 0) ? 2 : 8));
      end
      wait_table_idle();
    end

    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
